// ===== rtl/core/swem_pkg.sv =====
package swem_pkg;

    localparam logic [1:0]  REG_WINDOW_LEN = 2'd0;
    localparam logic [1:0]  REG_RATE_T     = 2'd1;

    localparam logic [8:0]  WIN_DEFAULT    = 9'd128;
    localparam logic [23:0] RATE_DEFAULT   = 24'd655;
    localparam logic [31:0] LN2_Q32        = 32'd2977044472;
    localparam logic [47:0] EXP_LIMIT      = 48'd28 << 16;
    localparam logic [4:0]  TAYLOR_TERMS   = 5'd16;
    localparam int          VALUE_W        = 48;

    // Floor of 2^32 / n for the series step divisors.
    function automatic logic [32:0] recip(input logic [4:0] n);
        begin
            case (n)
                5'd1:    recip = 33'd4294967296;
                5'd2:    recip = 33'd2147483648;
                5'd3:    recip = 33'd1431655765;
                5'd4:    recip = 33'd1073741824;
                5'd5:    recip = 33'd858993459;
                5'd6:    recip = 33'd715827882;
                5'd7:    recip = 33'd613566756;
                5'd8:    recip = 33'd536870912;
                5'd9:    recip = 33'd477218588;
                5'd10:   recip = 33'd429496729;
                5'd11:   recip = 33'd390451572;
                5'd12:   recip = 33'd357913941;
                5'd13:   recip = 33'd330382099;
                5'd14:   recip = 33'd306783378;
                5'd15:   recip = 33'd286331153;
                5'd16:   recip = 33'd268435456;
                default: recip = 33'd0;
            endcase
        end
    endfunction

endpackage

// ===== rtl/core/swem_ram.sv =====
module swem_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 4096
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/swem_exp.sv =====
module swem_exp #(
    parameter int EXP_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] x,
    output logic        done,
    output logic [48:0] e
);

    localparam logic [2:0] E_IDLE  = 3'd0;
    localparam logic [2:0] E_KDIV  = 3'd1;
    localparam logic [2:0] E_MUL   = 3'd2;
    localparam logic [2:0] E_RCP   = 3'd3;
    localparam logic [2:0] E_FIX   = 3'd4;
    localparam logic [2:0] E_SHIFT = 3'd5;
    localparam logic [2:0] E_DONE  = 3'd6;

    localparam logic [31:0] LN2_Q32_W = swem_pkg::LN2_Q32;

    logic [2:0]  st_reg, st_next;
    logic [36:0] bx_reg, bx_next;
    logic [5:0]  k_reg, k_next;
    logic [2:0]  bit_reg, bit_next;
    logic [32:0] term_reg, term_next;
    logic [31:0] z_reg, z_next;
    logic [39:0] sum_reg, sum_next;
    logic [4:0]  n_reg, n_next;
    logic [64:0] prod_reg, prod_next;
    logic [31:0] a_reg, a_next;
    logic [48:0] e_reg, e_next;

    logic [37:0] ln2_sh;
    logic [31:0] q0;
    logic [31:0] rem;
    logic [31:0] q;
    logic [63:0] sum_ext;
    logic [63:0] shifted;
    logic signed [7:0] sh;

    always_comb
    begin
        st_next   = st_reg;
        bx_next   = bx_reg;
        k_next    = k_reg;
        bit_next  = bit_reg;
        term_next = term_reg;
        z_next    = z_reg;
        sum_next  = sum_reg;
        n_next    = n_reg;
        prod_next = prod_reg;
        a_next    = a_reg;
        e_next    = e_reg;

        ln2_sh  = {6'd0, LN2_Q32_W} << bit_reg;
        q0      = prod_reg[63:32];
        rem     = a_reg - 32'(q0 * 32'(n_reg));
        q       = (rem >= 32'(n_reg)) ? q0 + 32'd1 : q0;
        sum_ext = 64'(sum_reg);
        sh      = 8'(int'(k_reg) + EXP_FRAC_BITS - 32);
        shifted = 64'd0;

        case (st_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    if (x >= swem_pkg::EXP_LIMIT)
                    begin
                        e_next  = {1'b1, 48'd0};
                        st_next = E_DONE;
                    end
                    else
                    begin
                        bx_next  = {x[20:0], 16'd0};
                        k_next   = 6'd0;
                        bit_next = 3'd5;
                        st_next  = E_KDIV;
                    end
                end
            end
            E_KDIV:
            begin
                if ({1'b0, bx_reg} >= ln2_sh)
                begin
                    bx_next        = bx_reg - ln2_sh[36:0];
                    k_next[bit_reg] = 1'b1;
                end
                if (bit_reg == 3'd0)
                begin
                    st_next = E_MUL;
                end
                else
                begin
                    bit_next = bit_reg - 3'd1;
                end
            end
            E_MUL:
            begin
                if (n_reg == 5'd0)
                begin
                    z_next    = bx_reg[31:0];
                    term_next = 33'h1_0000_0000;
                    sum_next  = 40'h01_0000_0000;
                    n_next    = 5'd1;
                    prod_next = {1'b0, bx_reg[31:0], 32'd0};
                end
                else
                begin
                    prod_next = {1'b0, {32'd0, term_reg[31:0]} * {32'd0, z_reg}};
                end
                st_next = E_RCP;
            end
            E_RCP:
            begin
                a_next    = prod_reg[63:32];
                prod_next = {33'd0, prod_reg[63:32]} * {32'd0, swem_pkg::recip(n_reg)};
                st_next   = E_FIX;
            end
            E_FIX:
            begin
                term_next = {1'b0, q};
                sum_next  = sum_reg + 40'(q);
                if (n_reg == swem_pkg::TAYLOR_TERMS)
                begin
                    st_next = E_SHIFT;
                end
                else
                begin
                    n_next  = n_reg + 5'd1;
                    st_next = E_MUL;
                end
            end
            E_SHIFT:
            begin
                if (sh >= 8'sd16)
                begin
                    e_next = {1'b1, 48'd0};
                end
                else if (sh >= 8'sd0)
                begin
                    shifted = sum_ext << sh[5:0];
                    e_next  = (shifted[63:48] != 16'd0) ? {1'b1, 48'd0}
                                                        : {1'b0, shifted[47:0]};
                end
                else
                begin
                    shifted = sum_ext >> 6'(-sh);
                    e_next  = {1'b0, shifted[47:0]};
                end
                st_next = E_DONE;
            end
            E_DONE:
            begin
                st_next = E_IDLE;
            end
            default:
            begin
                st_next = E_IDLE;
            end
        endcase

        if (st_reg == E_IDLE)
        begin
            n_next = 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= E_IDLE;
            n_reg  <= 5'd0;
        end
        else
        begin
            st_reg <= st_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bx_reg   <= bx_next;
        k_reg    <= k_next;
        bit_reg  <= bit_next;
        term_reg <= term_next;
        z_reg    <= z_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        a_reg    <= a_next;
        e_reg    <= e_next;
    end

    assign done = (st_reg == E_DONE);
    assign e    = e_reg;

endmodule

// ===== rtl/core/swem_div.sv =====
module swem_div #(
    parameter int DIVIDEND_W = 57,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/sliding_window_exp_mean_top.sv =====
// Sliding-window mean of exp(t * volume), kept per instrument.
// Input words arrive on s_tvalid/s_tready/s_tdata, one event each: instrument,
// timestamp and volume. A word with zero volume or an unknown instrument is
// dropped. Every other word updates that instrument's ring of the last
// window_len exponentials and, unless the window holds an overflow entry,
// gives one result word on m_tvalid/m_tready/m_tdata.
// The block works on one word at a time. A word with a positive volume has
// its result presented once the exponential unit and the divider finish,
// and the next word can be taken as it is presented. The exponential unit
// runs six range-reduction steps, a multiply, reciprocal and correction step
// for each of the 16 series terms, and a final scaling; the mean is formed by
// a divider that retires one quotient bit per cycle over 57 bits. A word that
// leaves an overflow entry frees the block with no division, and with no
// series if the exponent is out of range. A dropped word is taken in idle.
// Results pass through an output register, so the next word is accepted while
// a result still waits; if the receiver holds m_tready low the block stalls
// only when a second result is ready to be stored.
// Reset empties all windows and loads window_len = 128 and rate_t = 655.
// Writes on cfg_we/cfg_index/cfg_data take effect at once; the user is to make
// them only while the block is idle, which the block itself does not enforce;
// a change of the effective window length empties every window.
module sliding_window_exp_mean_top #(
    parameter int MAX_WINDOW      = 256,
    parameter int NUM_INSTRUMENTS = 16,
    parameter int EXP_FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // instrument[3:0], stamp_ms[51:4], volume[75:52]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // instrument_out[3:0], stamp_out[51:4],
                                    // mgf_value[99:52], fill_count[108:100]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int INST_AW  = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
    localparam int POS_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W    = swem_pkg::VALUE_W + CNT_W;
    localparam int ST_W     = POS_W + CNT_W + SUM_W + CNT_W;
    localparam int RING_D   = NUM_INSTRUMENTS * MAX_WINDOW;
    localparam int RING_AW  = $clog2(RING_D);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_LOAD  = 3'd1;
    localparam logic [2:0] T_EXPGO = 3'd2;
    localparam logic [2:0] T_EXPW  = 3'd3;
    localparam logic [2:0] T_UPD   = 3'd4;
    localparam logic [2:0] T_DIVGO = 3'd5;
    localparam logic [2:0] T_DIVW  = 3'd6;
    localparam logic [2:0] T_OUT   = 3'd7;

    function automatic logic [CNT_W-1:0] eff_len(input logic [8:0] w);
        logic [31:0] l;
        begin
            l = (w < 9'd2) ? 32'(swem_pkg::WIN_DEFAULT) : 32'(w);
            if (l > 32'(MAX_WINDOW))
            begin
                l = 32'(MAX_WINDOW);
            end
            eff_len = l[CNT_W-1:0];
        end
    endfunction

    logic [2:0]                 st_reg, st_next;
    logic [8:0]                 win_reg;
    logic [23:0]                rate_reg;
    logic [NUM_INSTRUMENTS-1:0] valid_reg;

    logic [3:0]          inst_reg;
    logic [INST_AW-1:0]  idx_reg;
    logic [47:0]         stamp_reg;
    logic [23:0]         vol_reg;
    logic [47:0]         x_reg;
    logic [RING_AW-1:0]  base_reg;
    logic [POS_W-1:0]    head_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CNT_W-1:0]    ovf_reg;
    logic [48:0]         e_reg;
    logic                out_valid_reg;
    logic [111:0]        out_data_reg;

    logic [3:0]          s_inst;
    logic                in_range;
    logic                accept;
    logic [CNT_W-1:0]    len;
    logic [23:0]         rate_eff;
    logic [ST_W-1:0]     st_rdata;
    logic [ST_W-1:0]     st_wdata;
    logic                st_we;
    logic [48:0]         ring_rdata;
    logic [RING_AW-1:0]  ring_raddr;
    logic [RING_AW-1:0]  ring_waddr;
    logic                ring_we;

    logic                evict;
    logic [CNT_W-1:0]    hp1;
    logic [POS_W-1:0]    head1;
    logic [CNT_W-1:0]    fill1;
    logic [SUM_W-1:0]    sum1;
    logic [CNT_W-1:0]    ovf1;
    logic [CNT_W:0]      wsum;
    logic [POS_W-1:0]    wpos;
    logic [CNT_W-1:0]    fill2;
    logic [SUM_W-1:0]    sum2;
    logic [CNT_W-1:0]    ovf2;

    logic                exp_start;
    logic                exp_done;
    logic [48:0]         exp_e;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_q;
    logic                out_free;

    assign s_inst   = s_tdata[3:0];
    assign in_range = 32'(s_inst) < 32'(NUM_INSTRUMENTS);
    assign s_tready = (st_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign len      = eff_len(win_reg);
    assign rate_eff = (rate_reg == 24'd0) ? swem_pkg::RATE_DEFAULT : rate_reg;
    assign out_free = !out_valid_reg || m_tready;

    swem_ram #(
        .WIDTH (ST_W),
        .DEPTH (NUM_INSTRUMENTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (idx_reg),
        .wdata (st_wdata),
        .raddr (INST_AW'(s_inst)),
        .rdata (st_rdata)
    );

    swem_ram #(
        .WIDTH (49),
        .DEPTH (RING_D)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (e_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    swem_exp #(
        .EXP_FRAC_BITS (EXP_FRAC_BITS)
    ) u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .x     (x_reg),
        .done  (exp_done),
        .e     (exp_e)
    );

    swem_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        evict = (fill_reg >= len);
        hp1   = CNT_W'(head_reg) + CNT_W'(1);
        head1 = head_reg;
        fill1 = fill_reg;
        sum1  = sum_reg;
        ovf1  = ovf_reg;
        if (evict)
        begin
            head1 = (hp1 == len) ? '0 : hp1[POS_W-1:0];
            fill1 = len - CNT_W'(1);
            if (ring_rdata[48])
            begin
                if (ovf_reg != '0)
                begin
                    ovf1 = ovf_reg - CNT_W'(1);
                end
            end
            else
            begin
                sum1 = sum_reg - SUM_W'(ring_rdata[47:0]);
            end
        end
        wsum  = (CNT_W + 1)'(head1) + (CNT_W + 1)'(fill1);
        wpos  = (wsum >= (CNT_W + 1)'(len)) ? POS_W'(wsum - (CNT_W + 1)'(len))
                                            : POS_W'(wsum);
        fill2 = fill1 + CNT_W'(1);
        ovf2  = e_reg[48] ? ovf1 + CNT_W'(1) : ovf1;
        sum2  = e_reg[48] ? sum1 : sum1 + SUM_W'(e_reg[47:0]);
    end

    assign ring_raddr = base_reg + RING_AW'(head_reg);
    assign ring_waddr = base_reg + RING_AW'(wpos);
    assign ring_we    = (st_reg == T_UPD);
    assign st_we      = (st_reg == T_UPD);
    assign st_wdata   = {ovf2, sum2, fill2, head1};
    assign exp_start  = (st_reg == T_EXPGO);
    assign div_start  = (st_reg == T_DIVGO);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            T_IDLE:
            begin
                if (accept && (s_tdata[75:52] != 24'd0) && in_range)
                begin
                    st_next = T_LOAD;
                end
            end
            T_LOAD:  st_next = T_EXPGO;
            T_EXPGO: st_next = T_EXPW;
            T_EXPW:
            begin
                if (exp_done)
                begin
                    st_next = T_UPD;
                end
            end
            T_UPD:   st_next = (ovf2 != '0) ? T_IDLE : T_DIVGO;
            T_DIVGO: st_next = T_DIVW;
            T_DIVW:
            begin
                if (div_done)
                begin
                    st_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_free)
                begin
                    st_next = T_IDLE;
                end
            end
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= T_IDLE;
            win_reg       <= swem_pkg::WIN_DEFAULT;
            rate_reg      <= swem_pkg::RATE_DEFAULT;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we && (cfg_index == swem_pkg::REG_WINDOW_LEN))
            begin
                win_reg <= cfg_data[8:0];
                if (eff_len(cfg_data[8:0]) != len)
                begin
                    valid_reg <= '0;
                end
            end
            else if (cfg_we && (cfg_index == swem_pkg::REG_RATE_T))
            begin
                rate_reg <= cfg_data;
            end
            else if (st_reg == T_UPD)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end

            if ((st_reg == T_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inst_reg  <= s_inst;
            idx_reg   <= INST_AW'(s_inst);
            stamp_reg <= s_tdata[51:4];
            vol_reg   <= s_tdata[75:52];
        end
        if (st_reg == T_LOAD)
        begin
            x_reg    <= {24'd0, rate_eff} * {24'd0, vol_reg};
            base_reg <= RING_AW'(32'(idx_reg) * 32'(MAX_WINDOW));
            if (valid_reg[idx_reg])
            begin
                {ovf_reg, sum_reg, fill_reg, head_reg} <= st_rdata;
            end
            else
            begin
                {ovf_reg, sum_reg, fill_reg, head_reg} <= '0;
            end
        end
        if ((st_reg == T_EXPW) && exp_done)
        begin
            e_reg <= exp_e;
        end
        if (st_reg == T_UPD)
        begin
            head_reg <= head1;
            fill_reg <= fill2;
            sum_reg  <= sum2;
            ovf_reg  <= ovf2;
        end
        if ((st_reg == T_OUT) && out_free)
        begin
            out_data_reg <= {3'd0, 9'(fill_reg), div_q[47:0], stamp_reg, inst_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_UPD) |-> (fill_reg <= len))
        else $error("window fill exceeds window length");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == T_UPD) |-> (CNT_W'(head_reg) < len))
        else $error("ring head outside the window");

    a_exp_done: assert property (@(posedge clk) disable iff (!rst_n)
        exp_done |-> (st_reg == T_EXPW))
        else $error("exponential finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == T_DIVW))
        else $error("divider finished outside its wait state");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == T_OUT) && out_free) |=> m_tvalid)
        else $error("result word was not presented");

endmodule
